### hw/rtl/obb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, constants and rounding helpers for the oriented box block.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int ENTRY_BITS  = 16;
    localparam int MAT_FRAC    = 12;
    localparam int COORD_FRAC  = COORD_BITS / 2;
    localparam int REG_BITS    = 48;
    localparam int NUM_REGS    = 4;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 64;
    localparam int NUM_PAIRS   = 6;

    localparam int CTR_SHIFT   = MAT_FRAC + 1;
    localparam int EXT_SHIFT   = 2 * MAT_FRAC + 1;

    // Unique column pairs of the symmetric Gram matrix, and the reverse map.
    localparam int PAIR_J [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_K [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};
    localparam int PIDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] ucoord_t;
    typedef logic signed [ENTRY_BITS-1:0] entry_t;
    typedef logic        [REG_BITS-1:0]   col_t;

    typedef enum logic [1:0] {
        REG_COL0 = 2'd0,
        REG_COL1 = 2'd1,
        REG_COL2 = 2'd2,
        REG_COL3 = 2'd3
    } reg_idx_t;

    typedef struct packed {
        col_t col3;
        col_t col2;
        col_t col1;
        col_t col0;
    } mat_t;

    typedef struct packed {
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } box_t;

    typedef struct packed {
        coord_t  center_x;
        coord_t  center_y;
        coord_t  center_z;
        ucoord_t extent_a;
        ucoord_t extent_b;
        ucoord_t extent_c;
    } obb_t;

    localparam col_t COL0_RST = 48'd4096;
    localparam col_t COL1_RST = 48'd268435456;
    localparam col_t COL2_RST = 48'd17592186044416;
    localparam col_t COL3_RST = 48'd0;

    // Divide by 2^13 rounding half away from zero, then clamp to the signed range.
    function automatic coord_t round_sat_center(input logic signed [35:0] n);
        logic [35:0] mag;
        logic [23:0] q;
        mag = n[35] ? 36'(-n) : 36'(n);
        q   = 24'((mag + 36'(37'd1 << (CTR_SHIFT - 1))) >> CTR_SHIFT);
        if (n[35])
        begin
            if (q > 24'd32768)
                return coord_t'(16'h8000);
            return coord_t'(-q[15:0]);
        end
        if (q > 24'd32767)
            return coord_t'(16'h7fff);
        return coord_t'(q[15:0]);
    endfunction

    // Divide by 2^25 rounding half up, then clamp at all ones.
    function automatic ucoord_t round_sat_extent(input logic [49:0] t);
        logic [25:0] r;
        r = 26'((t + (50'd1 << (EXT_SHIFT - 1))) >> EXT_SHIFT);
        if (r > 26'd65535)
            return '1;
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/obb_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obb_cfg
// APB register file holding the four matrix columns.
// ----------------------------------------------------------------------------
module obb_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [obb_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [obb_pkg::DATA_BITS-1:0] pwdata,
    output logic      [obb_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    output obb_pkg::mat_t                      mat
);
    import obb_pkg::*;

    mat_t     mat_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign mat    = mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg.col0 <= COL0_RST;
            mat_reg.col1 <= COL1_RST;
            mat_reg.col2 <= COL2_RST;
            mat_reg.col3 <= COL3_RST;
        end
        else if (wr)
        begin
            case (idx)
                REG_COL0: mat_reg.col0 <= pwdata[REG_BITS-1:0];
                REG_COL1: mat_reg.col1 <= pwdata[REG_BITS-1:0];
                REG_COL2: mat_reg.col2 <= pwdata[REG_BITS-1:0];
                REG_COL3: mat_reg.col3 <= pwdata[REG_BITS-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_COL0: prdata = DATA_BITS'(mat_reg.col0);
            REG_COL1: prdata = DATA_BITS'(mat_reg.col1);
            REG_COL2: prdata = DATA_BITS'(mat_reg.col2);
            REG_COL3: prdata = DATA_BITS'(mat_reg.col3);
            default:  prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/obb_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obb_pipe
// Four-stage datapath: Gram products and box sums, Gram sums and center
// products, extent products and center sum, then rounding and saturation.
// ----------------------------------------------------------------------------
module obb_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire obb_pkg::mat_t mat,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire obb_pkg::box_t in_beat,
    output logic               out_valid,
    input  wire logic          out_ready,
    output obb_pkg::obb_t      out_beat
);
    import obb_pkg::*;

    entry_t e [3][3];
    entry_t tr [3];
    coord_t lo [3];
    coord_t hi [3];

    logic [4:1] v_reg;
    logic [4:1] v_next;
    logic [4:1] en;

    logic signed [16:0] sum1_reg [3];
    logic signed [16:0] sum1_next [3];
    logic        [15:0] side1_reg [3];
    logic        [15:0] side1_next [3];
    logic signed [31:0] gp1_reg [NUM_PAIRS][3];
    logic signed [31:0] gp1_next [NUM_PAIRS][3];

    logic signed [32:0] cp2_reg [3][3];
    logic signed [32:0] cp2_next [3][3];
    logic        [31:0] ag2_reg [NUM_PAIRS];
    logic        [31:0] ag2_next [NUM_PAIRS];
    logic        [15:0] side2_reg [3];

    logic        [47:0] tp3_reg [3][3];
    logic        [47:0] tp3_next [3][3];
    logic signed [35:0] cn3_reg [3];
    logic signed [35:0] cn3_next [3];

    obb_t out_reg;
    obb_t out_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            e[0][c] = entry_t'(mat.col0[16*c +: 16]);
            e[1][c] = entry_t'(mat.col1[16*c +: 16]);
            e[2][c] = entry_t'(mat.col2[16*c +: 16]);
            tr[c]   = entry_t'(mat.col3[16*c +: 16]);
        end
        lo[0] = in_beat.box_min_x;
        lo[1] = in_beat.box_min_y;
        lo[2] = in_beat.box_min_z;
        hi[0] = in_beat.box_max_x;
        hi[1] = in_beat.box_max_y;
        hi[2] = in_beat.box_max_z;
    end

    // A stage moves when its slot is empty or the next stage takes its beat.
    assign en[4]     = !v_reg[4] || out_ready;
    assign en[3]     = !v_reg[3] || en[4];
    assign en[2]     = !v_reg[2] || en[3];
    assign en[1]     = !v_reg[1] || en[2];
    assign in_ready  = en[1];
    assign out_valid = v_reg[4];
    assign out_beat  = out_reg;

    always_comb
    begin
        v_next[1] = en[1] ? in_valid : v_reg[1];
        v_next[2] = en[2] ? v_reg[1] : v_reg[2];
        v_next[3] = en[3] ? v_reg[2] : v_reg[3];
        v_next[4] = en[4] ? v_reg[3] : v_reg[4];
    end

    always_comb
    begin
        logic signed [16:0] d;
        logic signed [33:0] g;
        logic        [49:0] t;
        for (int k = 0; k < 3; k++)
        begin
            d             = 17'(hi[k]) - 17'(lo[k]);
            sum1_next[k]  = 17'(hi[k]) + 17'(lo[k]);
            side1_next[k] = d[16] ? 16'(-d) : d[15:0];
        end
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            for (int i = 0; i < 3; i++)
                gp1_next[p][i] = 32'(e[PAIR_J[p]][i]) * 32'(e[PAIR_K[p]][i]);
            g           = 34'(gp1_reg[p][0]) + 34'(gp1_reg[p][1]) + 34'(gp1_reg[p][2]);
            ag2_next[p] = g[33] ? 32'(-g) : 32'(g);
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                cp2_next[i][k] = 33'(e[k][i]) * 33'(sum1_reg[k]);
            cn3_next[i] = 36'(cp2_reg[i][0]) + 36'(cp2_reg[i][1]) + 36'(cp2_reg[i][2])
                        + (36'(tr[i]) <<< (COORD_FRAC + 1));
        end
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
                tp3_next[j][k] = 48'(ag2_reg[PIDX[j][k]]) * 48'(side2_reg[k]);

        out_next.center_x = round_sat_center(cn3_reg[0]);
        out_next.center_y = round_sat_center(cn3_reg[1]);
        out_next.center_z = round_sat_center(cn3_reg[2]);
        t = 50'(tp3_reg[0][0]) + 50'(tp3_reg[0][1]) + 50'(tp3_reg[0][2]);
        out_next.extent_a = round_sat_extent(t);
        t = 50'(tp3_reg[1][0]) + 50'(tp3_reg[1][1]) + 50'(tp3_reg[1][2]);
        out_next.extent_b = round_sat_extent(t);
        t = 50'(tp3_reg[2][0]) + 50'(tp3_reg[2][1]) + 50'(tp3_reg[2][2]);
        out_next.extent_c = round_sat_extent(t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sum1_reg  <= sum1_next;
            side1_reg <= side1_next;
            gp1_reg   <= gp1_next;
        end
        if (en[2])
        begin
            cp2_reg   <= cp2_next;
            ag2_reg   <= ag2_next;
            side2_reg <= side1_reg;
        end
        if (en[3])
        begin
            tp3_reg <= tp3_next;
            cn3_reg <= cn3_next;
        end
        if (en[4])
            out_reg <= out_next;
    end

    // The input side only blocks when every stage is full and the sink stalls.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v_reg == 4'hf) && !out_ready)
        else $error("input blocked while the pipeline has room");

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[1])
        else $error("accepted beat lost at the first stage");

    // A beat in stage three with the output free reaches the output next cycle.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && en[4]) |=> out_valid)
        else $error("stage three beat did not reach the output");

endmodule
`default_nettype wire

### hw/rtl/oriented_box_from_aligned_box.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_box_from_aligned_box
// Converts an axis-aligned box into the center and half extents of the
// oriented box obtained by an affine matrix held in registers.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_beat) carries one box per beat
// as min and max corners in signed Q8.8. The output channel (out_valid,
// out_ready, out_beat) returns one beat per box: the center in signed Q8.8
// and three half extents in unsigned Q8.8, all saturated.
// The APB port holds the matrix: three linear columns and the translation,
// each three signed Q4.12 entries, at byte addresses 0, 8, 16 and 24.
// Write it only while no box is in flight.
// The datapath is a four-stage pipeline: stages one to three and the
// output register, which presents the result beat. A new box is taken
// every cycle unless all stages are full and the receiver stalls, since
// each stage holds one beat; the deepest stage is the third, with nine
// 32 by 16 bit extent multipliers, one for each column and side.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, each stage holds its beat and the pipeline
// compacts its bubbles; in_ready falls only once all four stages are full.
// ----------------------------------------------------------------------------
module oriented_box_from_aligned_box (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [obb_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [obb_pkg::DATA_BITS-1:0] pwdata,
    output logic      [obb_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire obb_pkg::box_t                 in_beat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output obb_pkg::obb_t                      out_beat
);
    import obb_pkg::*;

    // Matrix columns as currently configured.
    mat_t mat;

    obb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat)
    );

    // Read live; user keeps columns stable while beats flow (unenforced).
    obb_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

endmodule
`default_nettype wire
